/* hw/rtl/marching_squares_cell_classifier_top_assert.svh */
// Assertion helpers for the classifier top module.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef MARCHING_SQUARES_CELL_CLASSIFIER_TOP_ASSERT_SVH
`define MARCHING_SQUARES_CELL_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define MSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define MSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/msq_pkg.sv */
package msq_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_ISO_LEVEL = 1'b0;
  localparam logic REG_ROW_WIDTH = 1'b1;

  // Edge codes of a contour segment.
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  localparam logic [11:0] ROW_MAX = 12'd4095;

  // One sample request as it leaves the scan stage.
  typedef struct packed {
    logic        emit;
    logic        corner;
    logic [11:0] cell_row;
    logic [10:0] cell_col;
  } scan_req_t;

  // Segment description of one cell.
  typedef struct packed {
    logic [1:0] count;
    logic [1:0] first_from;
    logic [1:0] first_to;
    logic [1:0] second_from;
    logic [1:0] second_to;
  } seg_info_t;

  // Marching-squares segment table; unused segment fields are zero.
  function automatic seg_info_t seg_lookup(input logic [3:0] code);
    seg_info_t s;
    s = '0;
    case (code) inside
      4'd1, 4'd14: begin
        s.count = 2'd1; s.first_from = EDGE_LEFT; s.first_to = EDGE_BOTTOM;
      end
      4'd2, 4'd13: begin
        s.count = 2'd1; s.first_from = EDGE_BOTTOM; s.first_to = EDGE_RIGHT;
      end
      4'd3, 4'd12: begin
        s.count = 2'd1; s.first_from = EDGE_LEFT; s.first_to = EDGE_RIGHT;
      end
      4'd4, 4'd11: begin
        s.count = 2'd1; s.first_from = EDGE_TOP; s.first_to = EDGE_RIGHT;
      end
      4'd6, 4'd9: begin
        s.count = 2'd1; s.first_from = EDGE_TOP; s.first_to = EDGE_BOTTOM;
      end
      4'd7, 4'd8: begin
        s.count = 2'd1; s.first_from = EDGE_LEFT; s.first_to = EDGE_TOP;
      end
      4'd5: begin
        s.count = 2'd2; s.first_from = EDGE_LEFT; s.first_to = EDGE_TOP;
        s.second_from = EDGE_BOTTOM; s.second_to = EDGE_RIGHT;
      end
      4'd10: begin
        s.count = 2'd2; s.first_from = EDGE_TOP; s.first_to = EDGE_RIGHT;
        s.second_from = EDGE_LEFT; s.second_to = EDGE_BOTTOM;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/marching_squares_cell_classifier_top.sv */
// An accepted sample enters the classify stage, which drains into an output register.
// Throughput: one sample per cycle unless a cell waits on out_tready; the one-bit line
// buffer is read and written at one address per sample.
// Reset: row and column counters and the left and upper-left corner bits clear,
// iso_level returns to 0 and row_width to 2000; the line buffer is not cleared.
module marching_squares_cell_classifier_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] elevation
  input  logic        in_tuser,   // [0] frame_start
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] cell_row, [22:12] cell_col, [26:23] case_code, [28:27] segment_count,
  // [30:29] first_from_edge, [32:31] first_to_edge, [34:33] second_from_edge,
  // [36:35] second_to_edge, [39:37] zero
  output logic [39:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import msq_pkg::*;

  `include "marching_squares_cell_classifier_top_assert.svh"

  logic signed [31:0] iso_r, iso_nxt;
  logic [11:0]        width_r, width_nxt;
  logic               cfg_wr;

  scan_req_t  scan_req;
  logic       up_bit;
  logic       in_acc;

  logic       s1_v_r, s1_v_nxt;
  scan_req_t  s1_r;
  logic       s1_adv;
  logic       left_r, left_nxt, ul_r, ul_nxt;
  logic [3:0] code;
  seg_info_t  seg;

  logic       out_v_r, out_v_nxt;
  logic [39:0] out_data_r;

  logic       out_no_seg, out_two_seg, out_flat, out_saddle;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    iso_nxt   = iso_r;
    width_nxt = width_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ISO_LEVEL: iso_nxt   = cfg_pwdata;
        REG_ROW_WIDTH: width_nxt = cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ISO_LEVEL: cfg_prdata = iso_r;
      REG_ROW_WIDTH: cfg_prdata = {20'd0, width_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r   <= '0;
      width_r <= 12'd2000;
    end else begin
      iso_r   <= iso_nxt;
      width_r <= width_nxt;
    end
  end

  // Scan stage: position, threshold compare and line buffer access.
  assign in_acc = in_tvalid && in_tready;

  msq_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .elevation   (in_tdata),
    .frame_start (in_tuser),
    .iso_level   (iso_r),
    .row_width   (width_r),
    .req         (scan_req),
    .up_bit      (up_bit)
  );

  // Classify stage; a request without a cell never waits on the output.
  assign s1_adv    = s1_v_r && (!s1_r.emit || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign code      = {ul_r, up_bit, s1_r.corner, left_r};
  assign seg       = seg_lookup(code);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  assign left_nxt = s1_adv ? s1_r.corner : left_r;
  assign ul_nxt   = s1_adv ? up_bit : ul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      left_r <= 1'b0;
      ul_r   <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      left_r <= left_nxt;
      ul_r   <= ul_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= scan_req;
    end
  end

  // Output register.
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv && s1_r.emit) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_data_r <= {3'd0, seg.second_to, seg.second_from, seg.first_to, seg.first_from,
                     seg.count, code, s1_r.cell_col, s1_r.cell_row};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Shorthand views of the held result for the checks below.
  assign out_no_seg  = out_v_r && (out_data_r[28:27] == 2'd0);
  assign out_two_seg = out_v_r && (out_data_r[28:27] == 2'd2);
  assign out_flat    = (out_data_r[26:23] == 4'd0) || (out_data_r[26:23] == 4'd15);
  assign out_saddle  = (out_data_r[26:23] == 4'd5) || (out_data_r[26:23] == 4'd10);

  // The line buffer word must hold while the classify stage waits.
  `MSQ_ASSERT_NEXT(a_up_hold, s1_v_r && !s1_adv, $stable(up_bit), "line buffer word moved")
  // A cell without segments is all-below or all-above.
  `MSQ_ASSERT_NOW(a_empty_cell, out_no_seg, out_flat, "segment count zero on a crossed cell")
  // Only the saddle cases carry two segments.
  `MSQ_ASSERT_NOW(a_saddle, out_two_seg, out_saddle, "two segments outside a saddle case")
  // An accepted request always occupies the classify stage next cycle.
  `MSQ_ASSERT_NEXT(a_s1_fill, in_acc, s1_v_r, "accepted request lost before classify")

endmodule

/* hw/rtl/msq_ram.sv */
module msq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read and a write at the same address return the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/msq_scan.sv */
module msq_scan #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic signed [31:0] elevation,
  input  logic               frame_start,
  input  logic signed [31:0] iso_level,
  input  logic [11:0]        row_width,
  output msq_pkg::scan_req_t req,
  output logic               up_bit
);
  import msq_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [CW-1:0] col_r, col_nxt, col_eff;
  logic [11:0]   row_r, row_nxt, row_eff;
  logic [WW-1:0] w_ext, w_clamp, col_inc;
  logic          last_col;
  logic          corner;

  // Effective row width, held between 2 and the line buffer depth.
  always_comb begin
    w_ext = WW'(row_width);
    if (w_ext < WW'(2)) begin
      w_clamp = WW'(2);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
  end

  // Position of this sample; a frame start restarts at the origin.
  assign col_eff  = frame_start ? '0 : col_r;
  assign row_eff  = frame_start ? '0 : row_r;
  assign col_inc  = WW'(col_eff) + WW'(1);
  assign last_col = (col_inc >= w_clamp);
  assign corner   = (elevation > iso_level);

  // Raster position update, with the row count saturating.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = (row_eff != ROW_MAX) ? row_eff + 12'd1 : row_eff;
      end else begin
        col_nxt = CW'(col_inc);
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Request toward the classify stage.
  always_comb begin
    req.emit     = (row_eff != 12'd0) && (col_eff != '0);
    req.corner   = corner;
    req.cell_row = row_eff - 12'd1;
    req.cell_col = 11'(col_eff - CW'(1));
  end

  // Line buffer: each sample reads the bit above it and replaces it in the same cycle.
  msq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (col_eff),
    .wdata (corner),
    .re    (accept),
    .raddr (col_eff),
    .rdata (up_bit)
  );

endmodule

/* tb/marching_squares_cell_classifier_top_test.sv */
module marching_squares_cell_classifier_top_test;
  import msq_pkg::*;

  localparam int MAX_WIDTH = 2048;
  localparam int ROW_LIMIT = 4095;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 860;

  // One classified cell as it leaves the block.
  typedef struct {
    bit [11:0] cell_row;
    bit [10:0] cell_col;
    bit [3:0]  case_code;
    bit [1:0]  segment_count;
    bit [1:0]  first_from_edge;
    bit [1:0]  first_to_edge;
    bit [1:0]  second_from_edge;
    bit [1:0]  second_to_edge;
  } cell_result_t;

  // Tracks the raster position and the corner bits, and holds the cells still owed.
  class contour_scoreboard;
    bit [31:0]    iso_level;
    bit [11:0]    row_width;
    bit           line_bits [MAX_WIDTH];
    bit           left_corner;
    bit           upper_left_corner;
    int unsigned  col_count;
    int unsigned  row_count;
    cell_result_t pending_cells[$];
    int           failures;

    function new();
      iso_level = '0;
      row_width = 12'd2000;
      left_corner = 1'b0;
      upper_left_corner = 1'b0;
      col_count = 0;
      row_count = 0;
      failures = 0;
    endfunction

    // Widths outside the legal range are pinned to the nearest limit.
    function int unsigned effective_width();
      if (row_width < 2) return 2;
      if (row_width > MAX_WIDTH) return MAX_WIDTH;
      return row_width;
    endfunction

    function void note_register(logic index, bit [31:0] value);
      if (index == REG_ISO_LEVEL) begin
        iso_level = value;
      end else begin
        row_width = value[11:0];
      end
    endfunction

    function void note_sample(bit [31:0] elevation, bit frame_start);
      int unsigned  width;
      bit           corner;
      bit           upper;
      bit [3:0]     code;
      cell_result_t owed;
      width = effective_width();
      if (frame_start) begin
        col_count = 0;
        row_count = 0;
      end
      corner = $signed(elevation) > $signed(iso_level);
      upper = line_bits[col_count];

      // A cell closes once its lower-right corner arrives.
      if (row_count >= 1 && col_count >= 1) begin
        code = {upper_left_corner, upper, corner, left_corner};
        owed = '{default: 0};
        owed.cell_row = 12'(row_count - 1);
        owed.cell_col = 11'(col_count - 1);
        owed.case_code = code;
        owed.segment_count = 2'd1;
        case (code)
          4'd0, 4'd15: owed.segment_count = 2'd0;
          4'd1, 4'd14: begin
            owed.first_from_edge = EDGE_LEFT;
            owed.first_to_edge = EDGE_BOTTOM;
          end
          4'd2, 4'd13: begin
            owed.first_from_edge = EDGE_BOTTOM;
            owed.first_to_edge = EDGE_RIGHT;
          end
          4'd3, 4'd12: begin
            owed.first_from_edge = EDGE_LEFT;
            owed.first_to_edge = EDGE_RIGHT;
          end
          4'd4, 4'd11: begin
            owed.first_from_edge = EDGE_TOP;
            owed.first_to_edge = EDGE_RIGHT;
          end
          4'd6, 4'd9: begin
            owed.first_from_edge = EDGE_TOP;
            owed.first_to_edge = EDGE_BOTTOM;
          end
          4'd7, 4'd8: begin
            owed.first_from_edge = EDGE_LEFT;
            owed.first_to_edge = EDGE_TOP;
          end
          // The two saddle cases carry a pair of segments.
          4'd5: begin
            owed.segment_count = 2'd2;
            owed.first_from_edge = EDGE_LEFT;
            owed.first_to_edge = EDGE_TOP;
            owed.second_from_edge = EDGE_BOTTOM;
            owed.second_to_edge = EDGE_RIGHT;
          end
          4'd10: begin
            owed.segment_count = 2'd2;
            owed.first_from_edge = EDGE_TOP;
            owed.first_to_edge = EDGE_RIGHT;
            owed.second_from_edge = EDGE_LEFT;
            owed.second_to_edge = EDGE_BOTTOM;
          end
          default: owed.segment_count = 2'd0;
        endcase
        pending_cells.push_back(owed);
      end

      line_bits[col_count] = corner;
      upper_left_corner = upper;
      left_corner = corner;

      // Wrap at the row end; the row counter holds at its top value.
      if (col_count + 1 >= width) begin
        col_count = 0;
        if (row_count < ROW_LIMIT) row_count++;
      end else begin
        col_count++;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_cell(bit [39:0] data);
      cell_result_t want;
      if (pending_cells.size() == 0) begin
        $error("cell row %0d col %0d arrived with no sample waiting", data[11:0], data[22:12]);
        failures++;
        return;
      end
      want = pending_cells.pop_front();
      compare_field("cell_row", want.cell_row, data[11:0]);
      compare_field("cell_col", want.cell_col, data[22:12]);
      compare_field("case_code", want.case_code, data[26:23]);
      compare_field("segment_count", want.segment_count, data[28:27]);
      compare_field("first_from_edge", want.first_from_edge, data[30:29]);
      compare_field("first_to_edge", want.first_to_edge, data[32:31]);
      compare_field("second_from_edge", want.second_from_edge, data[34:33]);
      compare_field("second_to_edge", want.second_to_edge, data[36:35]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  contour_scoreboard sb = new();
  bit send_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;

  marching_squares_cell_classifier_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [31:0] pick_iso();
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom();
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic bit [11:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'($urandom_range(0, 1));
    if (r < 15) return 12'($urandom_range(2, 10));
    return 12'($urandom_range(11, 64));
  endfunction

  // Near the threshold corners flip often; mode 1 spans the full range, mode 2 picks edge values.
  function automatic bit [31:0] pick_elevation(int mode);
    case (mode)
      0: return sb.iso_level + $urandom_range(0, 8) - 4;
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          4: return sb.iso_level;
          default: return sb.iso_level + 1;
        endcase
      end
    endcase
  endfunction

  // Result side: random stalls on out_tready.
  always @(posedge clk) begin
    if (out_idle_on && stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= out_idle_on ? pick_gap() : 0;
    end
  end

  // Every accepted result is checked against the oldest owed cell.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_cell(out_tdata);
  end

  // Watchdog: too long without any accepted request on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Setup and access phase, then an idle pause so back-to-back writes stay apart.
  task automatic cfg_write(input logic index, input bit [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.note_register(index, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input bit [31:0] elevation, input bit frame_start);
    int gap;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= elevation;
    in_tuser <= frame_start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(elevation, frame_start);
  endtask

  // Hold the input until every owed cell is out, then let the pipeline settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One raster; with breaks on, it may restart early or change a register mid-frame.
  task automatic send_frame(input int count, input int mode, input bit breaks);
    int change_at;
    change_at = (breaks && count > 1 && $urandom_range(0, 4) == 0) ?
                $urandom_range(1, count - 1) : -1;
    for (int k = 0; k < count; k++) begin
      if (k == change_at) begin
        wait_drained();
        // Mid-frame the row never widens, so every line-buffer read hits a written entry.
        if ($urandom_range(0, 1)) begin
          cfg_write(REG_ROW_WIDTH, $urandom_range(2, sb.effective_width()));
        end else begin
          cfg_write(REG_ISO_LEVEL, pick_iso());
        end
      end
      send_sample(pick_elevation(mode), k == 0 || (breaks && $urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    bit [1:0]    corner_rows [7];
    bit [31:0]   low_values [3];
    int          random_items;
    int unsigned width;
    corner_rows = '{2'b10, 2'b01, 2'b10, 2'b00, 2'b00, 2'b11, 2'b11};
    low_values = '{32'h0, 32'h8000_0000, 32'hffff_ffff};
    random_items = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Width below the minimum acts as two: each row pair makes one cell, covering
    // both saddles, empty and full cells, and samples equal to the threshold.
    cfg_write(REG_ROW_WIDTH, 32'd1);
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 2; c++) begin
        send_sample(corner_rows[r][1 - c] ? (c ? 32'h1 : 32'h7fff_ffff) : low_values[r % 3],
                    r == 0 && c == 0);
      end
    end

    // Threshold at both extremes of its range.
    wait_drained();
    cfg_write(REG_ISO_LEVEL, 32'h7fff_ffff);
    cfg_write(REG_ROW_WIDTH, 32'd0);
    for (int k = 0; k < 4; k++) send_sample(k % 2 ? 32'h8000_0000 : 32'h7fff_ffff, k == 0);
    wait_drained();
    cfg_write(REG_ISO_LEVEL, 32'h8000_0000);
    for (int k = 0; k < 4; k++) begin
      send_sample((k == 0 || k == 3) ? 32'h7fff_ffff : 32'h8000_0000, k == 0);
    end

    // Row narrowed while the column counter sits past the new width.
    wait_drained();
    cfg_write(REG_ISO_LEVEL, 32'h0);
    cfg_write(REG_ROW_WIDTH, 32'd6);
    for (int k = 0; k < 10; k++) send_sample(pick_elevation(0), k == 0);
    wait_drained();
    cfg_write(REG_ROW_WIDTH, 32'd3);
    for (int k = 0; k < 5; k++) send_sample(pick_elevation(0), 1'b0);

    // Random rasters; every one starts with a frame mark so the line buffer is refilled.
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      send_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on <= $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1)) cfg_write(REG_ISO_LEVEL, pick_iso());
      cfg_write(REG_ROW_WIDTH, {20'd0, pick_width()});
      width = sb.effective_width();
      width = width * $urandom_range(2, 8) + $urandom_range(0, width - 1);
      // The last raster is cut short so the total matches the planned count.
      if (width > RANDOM_ITEMS - random_items) width = RANDOM_ITEMS - random_items;
      send_frame(width, $urandom_range(0, 2), 1'b1);
      random_items += width;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
